// ----- design/phc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package phc_pkg;

  localparam int ADC_W   = 10;
  localparam int VOLT_W  = 17;
  localparam int GAIN_W  = 16;
  localparam int PCT_W   = 7;
  localparam int DELAY_W = 8;
  localparam int Q8_W    = 15;
  localparam int ERR_W   = VOLT_W + 1;
  localparam int CFG_IDX_W = 3;

  localparam int PCT_FULL = 100;

  localparam logic [VOLT_W-1:0]  VOLT_PER_CODE = VOLT_W'(105);
  localparam logic [Q8_W-1:0]    Q8_FULL       = Q8_W'(25600);
  localparam logic [DELAY_W-1:0] NO_FIRE       = DELAY_W'(255);
  localparam logic [3:0]         SOLAR_START_S   = 4'd5;
  localparam logic [3:0]         UTILITY_START_S = 4'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUT_VOLTAGE   = 3'd0,
    REG_SETPOINT      = 3'd1,
    REG_KP_GAIN       = 3'd2,
    REG_KI_GAIN       = 3'd3,
    REG_SOLAR_MAX     = 3'd4,
    REG_UTILITY_MAX   = 3'd5,
    REG_SAMPLE_PERIOD = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [ADC_W-1:0] battery_adc;
    logic             grid_present;
    logic             second_tick;
  } phc_in_t;

  typedef struct packed {
    logic [PCT_W-1:0]   heating_power;
    logic [DELAY_W-1:0] fire_delay;
    logic               fire_enable;
    logic [PCT_W-1:0]   control_level;
    logic               updated;
  } phc_out_t;

  // start and finish strobes of a serial arithmetic unit
  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

  function automatic logic [Q8_W-1:0] clamp_q8(input logic signed [Q8_W+10:0] x);
    logic [Q8_W-1:0] r;
    if (x < 0) begin
      r = '0;
    end else if (x > $signed({11'd0, Q8_FULL})) begin
      r = Q8_FULL;
    end else begin
      r = x[Q8_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/phc_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
module phc_mul #(
  parameter int WA = 18,
  parameter int WB = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [WA-1:0] a,
  input  wire logic [WB-1:0]        b,
  output logic                      done,
  output logic signed [WA+WB:0]     prod
);
  import phc_pkg::*;

  localparam int CW = (WB > 1) ? $clog2(WB) : 1;

  logic signed [WA-1:0] a_q;
  logic signed [WA:0]   hi;
  logic [WB-1:0]        lo;
  logic [CW-1:0]        cnt;
  logic                 busy;
  logic signed [WA:0]   sum;

  // one multiplier bit per cycle, partial product shifted right
  assign sum  = lo[0] ? (hi + {a_q[WA-1], a_q}) : hi;
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(WB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      hi  <= '0;
      lo  <= b;
    end else if (busy) begin
      hi <= {sum[WA], sum[WA:1]};
      lo <= {sum[0], lo[WB-1:1]};
    end
  end

endmodule
`default_nettype wire

// ----- design/phc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module phc_div #(
  parameter int W       = 15,
  parameter int DIVISOR = 100
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] num,
  output logic              done,
  output logic [W-1:0]      quot
);
  import phc_pkg::*;

  localparam int RW = $clog2(DIVISOR) + 1;
  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]    sh;
  logic [RW-2:0]   rem;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [RW-1:0]   trial;
  logic [RW-1:0]   diff;
  logic            ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, sh[W-1]};
  assign diff  = trial - RW'(DIVISOR);
  assign ge    = (trial >= RW'(DIVISOR));
  assign quot  = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= num;
      rem <= '0;
    end else if (busy) begin
      sh  <= {sh[W-2:0], ge};
      rem <= ge ? diff[RW-2:0] : trial[RW-2:0];
    end
  end

endmodule
`default_nettype wire

// ----- design/pi_heater_phase_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Without a PI step a transaction goes from evaluation straight to emit; with
// one it adds two serial multiply passes and a serial divide by 100, each
// pair of units running side by side. One transaction at a time: the next
// input is taken once the result sits in the output register. Reset (rst,
// synchronous) loads the register defaults and the off state: delay 255,
// level and power zero.
module pi_heater_phase_controller (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire phc_pkg::phc_in_t              in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output phc_pkg::phc_out_t                  out_data,
  input  wire logic                          cfg_we,
  input  wire logic [phc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [phc_pkg::VOLT_W-1:0]    cfg_data
);
  import phc_pkg::*;

  localparam int MUL_B_W = GAIN_W;
  localparam int PROD_W  = ERR_W + MUL_B_W + 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EVAL = 7'b0000010,
    S_MUL1 = 7'b0000100,
    S_SUM  = 7'b0001000,
    S_MUL2 = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state;

  // configuration
  logic [VOLT_W-1:0] cut_voltage, setpoint_voltage;
  logic [GAIN_W-1:0] kp_gain, ki_gain;
  logic [PCT_W-1:0]  solar_max_power, utility_max_power, sample_period_s;

  // controller state
  logic              last_grid;
  logic [3:0]        startup_seconds;
  logic [PCT_W-1:0]  seconds_since_update;
  logic [Q8_W-1:0]   integral_term;
  logic [PCT_W-1:0]  held_power, held_level;
  logic [DELAY_W-1:0] held_delay;
  logic              updated;

  phc_in_t           item;
  logic [Q8_W-1:0]   p_q, i_q;
  logic              span_pos;

  // pass evaluation
  logic              grid_chg;
  logic [3:0]        startup_base, startup_next;
  logic [PCT_W-1:0]  ssu_next;
  logic [VOLT_W-1:0] vbat;
  logic              cut_off, run_step;
  logic [3:0]        start_limit;
  logic signed [ERR_W-1:0] err;

  // serial units
  unit_ctl_t         mul_p_ctl, mul_i_ctl, div_a_ctl, div_b_ctl;
  logic signed [ERR_W-1:0]   mul_a0, mul_a1;
  logic [MUL_B_W-1:0]        mul_b0, mul_b1;
  logic signed [PROD_W-1:0]  prod0, prod1;
  logic [Q8_W-1:0]           quot0, quot1;

  // PI step arithmetic
  logic signed [Q8_W+10:0]   p_raw, i_raw;
  logic [Q8_W:0]             pi_sum;
  logic [Q8_W-1:0]           sum_cl;
  logic [PCT_W-1:0]          level;
  logic [PCT_W-1:0]          max_sel, max_pow;
  logic [8:0]                five_m;
  logic [8:0]                heat_x2;
  logic [DELAY_W-1:0]        max_heat, span_mag;

  assign in_stall = (state != S_IDLE);

  // ---- pass evaluation ----
  assign grid_chg     = (item.grid_present != last_grid);
  assign startup_base = grid_chg ? 4'd0 : startup_seconds;
  assign startup_next = (item.second_tick && startup_base != 4'd15) ?
                        startup_base + 4'd1 : startup_base;
  assign ssu_next     = (item.second_tick && seconds_since_update != 7'd127) ?
                        seconds_since_update + 7'd1 : seconds_since_update;
  assign vbat         = VOLT_W'(item.battery_adc) * VOLT_PER_CODE;
  assign start_limit  = item.grid_present ? SOLAR_START_S : UTILITY_START_S;
  assign cut_off      = item.grid_present && (vbat < cut_voltage);
  assign run_step     = !cut_off && (startup_next > start_limit) &&
                        (ssu_next >= sample_period_s);
  assign err          = $signed({1'b0, vbat}) - $signed({1'b0, setpoint_voltage});

  // ---- PI step ----
  assign p_raw  = (Q8_W+11)'($signed(prod0[PROD_W-1:10]));
  assign i_raw  = (Q8_W+11)'($signed(prod1[PROD_W-1:10])) +
                  $signed({11'd0, integral_term});
  assign pi_sum = {1'b0, p_q} + {1'b0, i_q};
  assign sum_cl = (pi_sum > {1'b0, Q8_FULL}) ? Q8_FULL : pi_sum[Q8_W-1:0];
  assign level  = sum_cl[Q8_W-1:8];

  assign max_sel  = last_grid ? solar_max_power : utility_max_power;
  assign max_pow  = (max_sel > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : max_sel;
  assign five_m   = 9'(max_pow) * 9'd5;
  assign heat_x2  = 9'd510 - five_m;
  assign max_heat = heat_x2[8:1];
  assign span_mag = 8'd254 - max_heat;

  always_comb begin
    mul_a0 = err;
    mul_a1 = err;
    mul_b0 = kp_gain;
    mul_b1 = ki_gain;
    if (state == S_SUM) begin
      mul_a0 = ERR_W'(level);
      mul_a1 = ERR_W'(level);
      mul_b0 = MUL_B_W'(max_pow);
      mul_b1 = MUL_B_W'(span_mag);
    end
  end

  assign mul_p_ctl.start = (state == S_EVAL && run_step) || (state == S_SUM);
  assign mul_i_ctl.start = mul_p_ctl.start;
  assign div_a_ctl.start = (state == S_MUL2) && mul_p_ctl.done;
  assign div_b_ctl.start = div_a_ctl.start;

  phc_mul #(.WA(ERR_W), .WB(MUL_B_W)) u_mul_p (
    .clk, .rst, .start(mul_p_ctl.start), .a(mul_a0), .b(mul_b0),
    .done(mul_p_ctl.done), .prod(prod0)
  );

  phc_mul #(.WA(ERR_W), .WB(MUL_B_W)) u_mul_i (
    .clk, .rst, .start(mul_i_ctl.start), .a(mul_a1), .b(mul_b1),
    .done(mul_i_ctl.done), .prod(prod1)
  );

  phc_div #(.W(Q8_W), .DIVISOR(PCT_FULL)) u_div_a (
    .clk, .rst, .start(div_a_ctl.start), .num(prod0[Q8_W-1:0]),
    .done(div_a_ctl.done), .quot(quot0)
  );

  phc_div #(.W(Q8_W), .DIVISOR(PCT_FULL)) u_div_b (
    .clk, .rst, .start(div_b_ctl.start), .num(prod1[Q8_W-1:0]),
    .done(div_b_ctl.done), .quot(quot1)
  );

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      cut_voltage       <= VOLT_W'(12800);
      setpoint_voltage  <= VOLT_W'(14848);
      kp_gain           <= GAIN_W'(2560);
      ki_gain           <= GAIN_W'(2560);
      solar_max_power   <= PCT_W'(100);
      utility_max_power <= PCT_W'(50);
      sample_period_s   <= PCT_W'(5);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CUT_VOLTAGE:   cut_voltage       <= cfg_data;
        REG_SETPOINT:      setpoint_voltage  <= cfg_data;
        REG_KP_GAIN:       kp_gain           <= cfg_data[GAIN_W-1:0];
        REG_KI_GAIN:       ki_gain           <= cfg_data[GAIN_W-1:0];
        REG_SOLAR_MAX:     solar_max_power   <= cfg_data[PCT_W-1:0];
        REG_UTILITY_MAX:   utility_max_power <= cfg_data[PCT_W-1:0];
        REG_SAMPLE_PERIOD: sample_period_s   <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
    if (state == S_MUL1 && mul_p_ctl.done) begin
      p_q <= clamp_q8(p_raw);
      i_q <= clamp_q8(i_raw);
    end
    if (state == S_SUM) begin
      span_pos <= (max_pow == '0);
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      out_valid            <= 1'b0;
      last_grid            <= 1'b1;
      startup_seconds      <= '0;
      seconds_since_update <= '0;
      integral_term        <= '0;
      held_power           <= '0;
      held_delay           <= NO_FIRE;
      held_level           <= '0;
      updated              <= 1'b0;
    end else begin
      if (state == S_EMIT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          last_grid            <= item.grid_present;
          startup_seconds      <= startup_next;
          seconds_since_update <= run_step ? '0 : ssu_next;
          updated              <= run_step;
          if (grid_chg || cut_off) begin
            integral_term <= '0;
            held_power    <= '0;
            held_delay    <= NO_FIRE;
            held_level    <= '0;
          end
          state <= run_step ? S_MUL1 : S_EMIT;
        end
        S_MUL1: begin
          if (mul_p_ctl.done) begin
            integral_term <= clamp_q8(i_raw);
            state         <= S_SUM;
          end
        end
        S_SUM: begin
          held_level <= level;
          state      <= S_MUL2;
        end
        S_MUL2: begin
          if (mul_p_ctl.done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_a_ctl.done) begin
            held_power <= quot0[PCT_W-1:0];
            held_delay <= span_pos ? NO_FIRE : NO_FIRE - quot1[DELAY_W-1:0];
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!out_valid || !out_stall)) begin
      out_data.heating_power <= held_power;
      out_data.fire_delay    <= held_delay;
      out_data.fire_enable   <= (held_delay != NO_FIRE);
      out_data.control_level <= held_level;
      out_data.updated       <= updated;
    end
  end

  // ---- checks ----
  a_mul_lockstep: assert property (@(posedge clk) disable iff (rst)
    mul_p_ctl.done == mul_i_ctl.done)
    else $error("multiplier pair out of step");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    div_a_ctl.done == div_b_ctl.done)
    else $error("divider pair out of step");

  a_integral_range: assert property (@(posedge clk) disable iff (rst)
    integral_term <= Q8_FULL)
    else $error("integral out of range");

  a_zero_level_no_fire: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && held_level == '0) |-> held_delay == NO_FIRE)
    else $error("firing with zero level");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    held_level <= PCT_W'(PCT_FULL))
    else $error("level above full scale");

endmodule
`default_nettype wire
